[rtl/udpd_pkg.sv]
// types, constants and helper functions for the url decode and path depth check
// used by url_decode_path_depth_check_core; has no dependencies of its own
package udpd_pkg;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        decoded_byte;
    logic              done_res;
    logic [1:0]        verdict;
    logic signed [11:0] path_depth;
  } out_beat_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_e;

  typedef enum logic [2:0] {
    SEG_START  = 3'd0,
    SEG_SLASH  = 3'd1,
    SEG_DOT    = 3'd2,
    SEG_DOTDOT = 3'd3,
    SEG_OTHER  = 3'd4
  } seg_class_e;

  // also used for the recorded first error (never VERD_DEPTH there)
  typedef enum logic [1:0] {
    VERD_OK     = 2'd0,
    VERD_ESCAPE = 2'd1,
    VERD_LONG   = 2'd2,
    VERD_DEPTH  = 2'd3
  } verdict_e;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // length of the "./website" prefix and of "/index.html"
  localparam int unsigned PREFIX_LEN = 9;
  localparam int unsigned ROOT_LEN   = 11;

  localparam logic signed [11:0] DEPTH_MAX = 12'sd2047;
  localparam logic signed [11:0] DEPTH_MIN = -12'sd2048;
  localparam logic signed [11:0] DEPTH_ROOT = 12'sd1;

  // {ok, nibble} for one ascii hex digit of either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // close a segment: "/.." lowers, "/." keeps, anything else raises, saturating
  function automatic logic signed [11:0] add_depth(input logic signed [11:0] d,
                                                   input seg_class_e cls);
    logic signed [11:0] r;
    r = d;
    if (cls == SEG_DOTDOT) begin
      if (d != DEPTH_MIN) r = d - 12'sd1;
    end else if (cls != SEG_DOT) begin
      if (d != DEPTH_MAX) r = d + 12'sd1;
    end
    return r;
  endfunction

endpackage

[rtl/url_decode_path_depth_check_core.sv]
// url percent decoder with path depth and length check, top level
// depends on udpd_pkg for beat types, codes and the hex and depth helpers
//
// usage:
//   input channel: one raw url byte per beat (in_beat_i), last_byte set on the
//   final byte of a url. output channel: a beat for every byte that decodes
//   to a path byte and for every last byte; the last one carries done_res,
//   the verdict and the final path depth. an escape digit that yields no byte
//   gives no output beat unless it is the last byte.
//   an accepted beat sits in the input register, and its result is loaded
//   into the output register once it is free, then shows on out_valid_o.
//   throughput: one byte per cycle unless out_stall_i holds the output; the
//   per-byte state (escape phase, counts, segment class, depth, first error)
//   updates once for each byte taken from the input register.
//   reset: clears both registers' valid flags and all decode state; after the
//   last byte of a url the state returns to its reset values on its own.
//   stall: while out_stall_i holds a result, it stays put; the input register
//   can still take one beat, then in_stall_o rises until the output drains.
module url_decode_path_depth_check_core #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  udpd_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output udpd_pkg::out_beat_t out_beat_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_LEN);
  localparam logic [CW:0]   LEN_LIMIT = (CW + 1)'(MAX_LEN);
  localparam logic [CW:0]   PREFIX_W  = (CW + 1)'(udpd_pkg::PREFIX_LEN);
  localparam logic [CW-1:0] ROOT_W    = CW'(udpd_pkg::ROOT_LEN);

  // input register
  logic               in_valid_q;
  udpd_pkg::in_beat_t in_q;

  // output register
  logic                out_valid_q, out_valid_d;
  udpd_pkg::out_beat_t out_q, out_d;

  // decode state
  udpd_pkg::esc_phase_e esc_q, esc_d;
  logic [3:0]           hi_nib_q, hi_nib_d;
  logic [CW-1:0]        dec_cnt_q, dec_cnt_d;
  logic [CW-1:0]        cut_cnt_q, cut_cnt_d;
  logic                 cut_seen_q, cut_seen_d;
  udpd_pkg::seg_class_e seg_q, seg_d;
  logic signed [11:0]   depth_q, depth_d;
  udpd_pkg::verdict_e   err_q, err_d;

  logic out_free;
  logic advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_beat_i;
    end
  end

  logic [7:0]         b;
  logic               last;
  logic [4:0]         hex;
  logic               fresh;
  logic               is_root;
  logic               byte_ok;
  logic [7:0]         ob;
  logic signed [11:0] fin_depth;
  logic [CW-1:0]      dlen, clen;
  udpd_pkg::verdict_e verdict;

  always_comb begin
    b    = in_q.url_byte;
    last = in_q.last_byte;
    hex  = udpd_pkg::hex_digit(b);

    esc_d      = esc_q;
    hi_nib_d   = hi_nib_q;
    dec_cnt_d  = dec_cnt_q;
    cut_cnt_d  = cut_cnt_q;
    cut_seen_d = cut_seen_q;
    seg_d      = seg_q;
    depth_d    = depth_q;
    err_d      = err_q;
    byte_ok    = 1'b0;
    ob         = 8'h00;

    fresh   = (dec_cnt_q == '0) && (esc_q == udpd_pkg::ESC_IDLE)
              && (err_q == udpd_pkg::VERD_OK);
    is_root = fresh && (b == udpd_pkg::CHAR_SLASH);

    case (esc_q)
      udpd_pkg::ESC_HIGH: begin
        if (!hex[4] || last) begin
          if (err_d == udpd_pkg::VERD_OK) err_d = udpd_pkg::VERD_ESCAPE;
          esc_d = udpd_pkg::ESC_IDLE;
        end else begin
          hi_nib_d = hex[3:0];
          esc_d    = udpd_pkg::ESC_LOW;
        end
      end
      udpd_pkg::ESC_LOW: begin
        esc_d = udpd_pkg::ESC_IDLE;
        if (!hex[4]) begin
          if (err_d == udpd_pkg::VERD_OK) err_d = udpd_pkg::VERD_ESCAPE;
        end else begin
          byte_ok = 1'b1;
          ob      = {hi_nib_q, hex[3:0]};
        end
      end
      default: begin
        esc_d = udpd_pkg::ESC_IDLE;
        if (b == udpd_pkg::CHAR_PERCENT) begin
          // length check comes before any digit check
          if ({1'b0, dec_cnt_q} + 1'b1 >= LEN_LIMIT) begin
            if (err_d == udpd_pkg::VERD_OK) err_d = udpd_pkg::VERD_LONG;
          end
          if (last) begin
            if (err_d == udpd_pkg::VERD_OK) err_d = udpd_pkg::VERD_ESCAPE;
          end else begin
            esc_d = udpd_pkg::ESC_HIGH;
          end
        end else begin
          byte_ok = 1'b1;
          ob      = b;
        end
      end
    endcase

    if (byte_ok) begin
      if (dec_cnt_q < CNT_MAX) dec_cnt_d = dec_cnt_q + 1'b1;
      if (!cut_seen_q) begin
        if (ob == udpd_pkg::CHAR_NUL) begin
          cut_seen_d = 1'b1;
        end else begin
          if (cut_cnt_q < CNT_MAX) cut_cnt_d = cut_cnt_q + 1'b1;
          if (ob == udpd_pkg::CHAR_SLASH && seg_q != udpd_pkg::SEG_START) begin
            depth_d = udpd_pkg::add_depth(depth_q, seg_q);
            seg_d   = udpd_pkg::SEG_SLASH;
          end else begin
            case (seg_q)
              udpd_pkg::SEG_START:
                seg_d = (ob == udpd_pkg::CHAR_SLASH) ? udpd_pkg::SEG_SLASH
                                                     : udpd_pkg::SEG_OTHER;
              udpd_pkg::SEG_SLASH:
                seg_d = (ob == udpd_pkg::CHAR_DOT) ? udpd_pkg::SEG_DOT
                                                   : udpd_pkg::SEG_OTHER;
              udpd_pkg::SEG_DOT:
                seg_d = (ob == udpd_pkg::CHAR_DOT) ? udpd_pkg::SEG_DOTDOT
                                                   : udpd_pkg::SEG_OTHER;
              default:
                seg_d = udpd_pkg::SEG_OTHER;
            endcase
          end
        end
      end
    end

    // a url of just "/" is judged as "/index.html"
    dlen      = is_root ? ROOT_W : dec_cnt_d;
    clen      = is_root ? ROOT_W : cut_cnt_d;
    fin_depth = is_root ? udpd_pkg::DEPTH_ROOT : udpd_pkg::add_depth(depth_d, seg_d);

    if (err_d != udpd_pkg::VERD_OK) begin
      verdict = err_d;
    end else if ({1'b0, dlen} >= LEN_LIMIT) begin
      verdict = udpd_pkg::VERD_LONG;
    end else if (fin_depth <= 12'sd0) begin
      verdict = udpd_pkg::VERD_DEPTH;
    end else if (PREFIX_W + {1'b0, clen} >= LEN_LIMIT) begin
      verdict = udpd_pkg::VERD_LONG;
    end else begin
      verdict = udpd_pkg::VERD_OK;
    end

    out_d.byte_valid   = byte_ok;
    out_d.decoded_byte = ob;
    out_d.done_res     = last;
    out_d.verdict      = last ? verdict : udpd_pkg::VERD_OK;
    out_d.path_depth   = last ? fin_depth : 12'sd0;

    // end of url: back to the reset state for the next one
    if (last) begin
      esc_d      = udpd_pkg::ESC_IDLE;
      hi_nib_d   = 4'd0;
      dec_cnt_d  = '0;
      cut_cnt_d  = '0;
      cut_seen_d = 1'b0;
      seg_d      = udpd_pkg::SEG_START;
      depth_d    = 12'sd0;
      err_d      = udpd_pkg::VERD_OK;
    end

    if (advance) begin
      out_valid_d = byte_ok || last;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= udpd_pkg::ESC_IDLE;
      hi_nib_q    <= 4'd0;
      dec_cnt_q   <= '0;
      cut_cnt_q   <= '0;
      cut_seen_q  <= 1'b0;
      seg_q       <= udpd_pkg::SEG_START;
      depth_q     <= 12'sd0;
      err_q       <= udpd_pkg::VERD_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        esc_q      <= esc_d;
        hi_nib_q   <= hi_nib_d;
        dec_cnt_q  <= dec_cnt_d;
        cut_cnt_q  <= cut_cnt_d;
        cut_seen_q <= cut_seen_d;
        seg_q      <= seg_d;
        depth_q    <= depth_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (byte_ok || last)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

[sim/udpd_out_checker.sv]
// output checker for url_decode_path_depth_check_core: watches both channels,
// predicts every output beat from the accepted url bytes and compares fields
// depends on udpd_pkg for the beat types and the escape, segment and verdict codes
module udpd_out_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  udpd_pkg::in_beat_t  in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  udpd_pkg::out_beat_t out_beat_i,
  output int unsigned         open_results_o,
  output int unsigned         fail_count_o
);

  // decode and path state of the url in progress
  udpd_pkg::esc_phase_e esc_phase;
  logic [3:0]           hi_nibble;
  int unsigned          decoded_len;
  int unsigned          cut_len;
  logic                 cut_hit;
  udpd_pkg::seg_class_e seg;
  int                   depth;
  udpd_pkg::verdict_e   first_err;

  udpd_pkg::out_beat_t predicted_beats[$];
  udpd_pkg::out_beat_t want;
  int unsigned         fails = 0;

  assign fail_count_o = fails;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  // closing a segment: dot-dot goes up a level, a lone dot stays put
  function automatic int step_depth(int d, udpd_pkg::seg_class_e cls);
    int r;
    r = d;
    if (cls == udpd_pkg::SEG_DOTDOT) r = d - 1;
    else if (cls != udpd_pkg::SEG_DOT) r = d + 1;
    if (r > 2047) r = 2047;
    if (r < -2048) r = -2048;
    return r;
  endfunction

  task automatic clear_state();
    esc_phase   = udpd_pkg::ESC_IDLE;
    hi_nibble   = 4'h0;
    decoded_len = 0;
    cut_len     = 0;
    cut_hit     = 1'b0;
    seg         = udpd_pkg::SEG_START;
    depth       = 0;
    first_err   = udpd_pkg::VERD_OK;
  endtask

  task automatic note_error(udpd_pkg::verdict_e code);
    if (first_err == udpd_pkg::VERD_OK) first_err = code;
  endtask

  task automatic follow_path(logic [7:0] b);
    if (cut_hit) return;
    if (b == udpd_pkg::CHAR_NUL) begin
      cut_hit = 1'b1;
      return;
    end
    if (cut_len < MAX_LEN) cut_len++;
    if (b == udpd_pkg::CHAR_SLASH && seg != udpd_pkg::SEG_START) begin
      depth = step_depth(depth, seg);
      seg = udpd_pkg::SEG_SLASH;
      return;
    end
    case (seg)
      udpd_pkg::SEG_START:
        seg = (b == udpd_pkg::CHAR_SLASH) ? udpd_pkg::SEG_SLASH : udpd_pkg::SEG_OTHER;
      udpd_pkg::SEG_SLASH:
        seg = (b == udpd_pkg::CHAR_DOT) ? udpd_pkg::SEG_DOT : udpd_pkg::SEG_OTHER;
      udpd_pkg::SEG_DOT:
        seg = (b == udpd_pkg::CHAR_DOT) ? udpd_pkg::SEG_DOTDOT : udpd_pkg::SEG_OTHER;
      default:
        seg = udpd_pkg::SEG_OTHER;
    endcase
  endtask

  task automatic decode_url_byte(udpd_pkg::in_beat_t ib);
    int                  nib;
    int                  d;
    logic                root;
    logic                emit;
    logic [7:0]          ob;
    int unsigned         dlen;
    int unsigned         clen;
    udpd_pkg::verdict_e  v;
    udpd_pkg::out_beat_t res;
    // a url that is just a slash is judged as the index page
    root = decoded_len == 0 && esc_phase == udpd_pkg::ESC_IDLE &&
           first_err == udpd_pkg::VERD_OK && ib.url_byte == udpd_pkg::CHAR_SLASH;
    emit = 1'b0;
    ob   = 8'h00;
    nib  = hex_nibble(ib.url_byte);
    case (esc_phase)
      udpd_pkg::ESC_HIGH: begin
        esc_phase = udpd_pkg::ESC_IDLE;
        if (nib < 0 || ib.last_byte) begin
          note_error(udpd_pkg::VERD_ESCAPE);
        end else begin
          hi_nibble = nib[3:0];
          esc_phase = udpd_pkg::ESC_LOW;
        end
      end
      udpd_pkg::ESC_LOW: begin
        esc_phase = udpd_pkg::ESC_IDLE;
        if (nib < 0) begin
          note_error(udpd_pkg::VERD_ESCAPE);
        end else begin
          emit = 1'b1;
          ob   = {hi_nibble, nib[3:0]};
        end
      end
      default: begin
        esc_phase = udpd_pkg::ESC_IDLE;
        if (ib.url_byte == udpd_pkg::CHAR_PERCENT) begin
          // length is judged before the digits are seen
          if (decoded_len + 1 >= MAX_LEN) note_error(udpd_pkg::VERD_LONG);
          if (ib.last_byte) note_error(udpd_pkg::VERD_ESCAPE);
          else esc_phase = udpd_pkg::ESC_HIGH;
        end else begin
          emit = 1'b1;
          ob   = ib.url_byte;
        end
      end
    endcase

    if (emit) begin
      if (decoded_len < MAX_LEN) decoded_len++;
      follow_path(ob);
    end

    if (emit || ib.last_byte) begin
      res = '0;
      res.byte_valid   = emit;
      res.decoded_byte = ob;
      res.done_res     = ib.last_byte;
      if (ib.last_byte) begin
        dlen = root ? udpd_pkg::ROOT_LEN : decoded_len;
        clen = root ? udpd_pkg::ROOT_LEN : cut_len;
        d    = root ? 1 : step_depth(depth, seg);
        if (first_err != udpd_pkg::VERD_OK) v = first_err;
        else if (dlen >= MAX_LEN) v = udpd_pkg::VERD_LONG;
        else if (d <= 0) v = udpd_pkg::VERD_DEPTH;
        else if (udpd_pkg::PREFIX_LEN + clen >= MAX_LEN) v = udpd_pkg::VERD_LONG;
        else v = udpd_pkg::VERD_OK;
        res.verdict    = v;
        res.path_depth = 12'(d);
        clear_state();
      end
      predicted_beats.push_back(res);
    end
  endtask

  task automatic check_field(string name, logic [11:0] exp_val, logic [11:0] act_val);
    if (act_val !== exp_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      predicted_beats.delete();
      open_results_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_beats.size() == 0) begin
          fails++;
          $display("%0t: output beat with nothing expected, expected none, actual %p",
                   $time, out_beat_i);
        end else begin
          want = predicted_beats.pop_front();
          check_field("byte_valid", want.byte_valid, out_beat_i.byte_valid);
          check_field("decoded_byte", want.decoded_byte, out_beat_i.decoded_byte);
          check_field("done_res", want.done_res, out_beat_i.done_res);
          check_field("verdict", want.verdict, out_beat_i.verdict);
          check_field("path_depth", want.path_depth, out_beat_i.path_depth);
        end
      end
      if (in_valid_i && !in_stall_i) decode_url_byte(in_beat_i);
      open_results_o <= predicted_beats.size();
    end
  end

endmodule

[sim/url_decode_path_depth_check_core_tb.sv]
// testbench top for url_decode_path_depth_check_core: feeds directed and random
// urls under varying backpressure and gives the verdict
// depends on udpd_pkg, the core and udpd_out_checker
module url_decode_path_depth_check_core_tb;

  localparam int unsigned MAX_LEN       = 1024;
  localparam int unsigned PHASE_BYTES   = 170;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  udpd_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  udpd_pkg::out_beat_t out_beat;

  int unsigned open_results;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0] url_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  url_decode_path_depth_check_core #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  udpd_out_checker #(
    .MAX_LEN(MAX_LEN)
  ) out_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_beat_i     (in_beat),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_beat_i    (out_beat),
    .open_results_o(open_results),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off whenever one is requested
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{url_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_url();
    for (int i = 0; i < url_q.size(); i++) send_byte(url_q[i], i == url_q.size() - 1);
    bytes_sent += url_q.size();
  endtask

  // sender pause: nothing offered until every predicted beat is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) url_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + n;
    return (upper ? 8'h37 : 8'h57) + n;
  endfunction

  task automatic push_escape(logic [7:0] v);
    url_q.push_back(udpd_pkg::CHAR_PERCENT);
    url_q.push_back(hex_char(v[7:4], $urandom_range(0, 1)));
    url_q.push_back(hex_char(v[3:0], $urandom_range(0, 1)));
  endtask

  task automatic push_name();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0:       url_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
        1:       url_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
        default: url_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic add_segment();
    url_q.push_back(udpd_pkg::CHAR_SLASH);
    case ($urandom_range(0, 12))
      0, 1: push_str("..");
      2:    push_str("%2e%2E");
      3:    push_str(".");
      4:    ;
      5:    push_escape(8'($urandom_range(0, 255)));
      6:    url_q.push_back(8'($urandom_range(0, 255)));
      7: begin
        // non-hex digit, either first or second
        url_q.push_back(udpd_pkg::CHAR_PERCENT);
        if ($urandom_range(0, 1)) url_q.push_back(hex_char(4'($urandom), 1'b0));
        url_q.push_back(8'h67 + 8'($urandom_range(0, 19)));
      end
      8: begin
        push_escape(8'h00);
        push_str("/..");
      end
      default: push_name();
    endcase
  endtask

  task automatic build_random_url();
    int kind;
    url_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      push_str("/");
      return;
    end
    if (kind == 1) begin
      repeat ($urandom_range(1, 12)) url_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 2) push_name();
    repeat ($urandom_range(0, 6)) add_segment();
    if (url_q.size() == 0) url_q.push_back(8'($urandom_range(0, 255)));
    // escape cut short by the end of the url
    if (kind == 3) url_q.push_back(udpd_pkg::CHAR_PERCENT);
    if (kind == 4) begin
      url_q.push_back(udpd_pkg::CHAR_PERCENT);
      url_q.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
    end
  endtask

  task automatic send_text(string s);
    url_q.delete();
    push_str(s);
    send_url();
  endtask

  initial begin
    int unsigned phase_end;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 88;
    send_text("/");
    send_text("/..");
    send_text("%2F%fA/.");
    send_text("%g");
    send_text("%4z");
    send_text("%4");
    send_text("%");
    send_text("/%00");
    url_q.delete();
    push_str("a");
    url_q.push_back(udpd_pkg::CHAR_NUL);
    push_str("/..");
    send_url();
    url_q = '{8'hFF};
    send_url();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      hold_requests++;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random_url();
        send_url();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
